>>> sv/spf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subpixel peak fit package
// Shared widths, configuration register indexes and status codes.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int COORD_BITS_DEF    = 12;
   localparam int OUT_FRAC_BITS_DEF = 8;
   localparam int IN_FRAC_BITS      = 4;

   localparam int PIX_W  = 8;
   localparam int DX_W   = 9;
   localparam int DH_W   = 11;
   localparam int PR_W   = 22;
   localparam int DT_W   = 25;
   localparam int NX_W   = 22;
   localparam int DEN_W  = 24;

   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [CSR_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [CSR_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OOB      = 2'd1,
      STATUS_SINGULAR = 2'd2,
      STATUS_OFFSET   = 2'd3
   } status_type;

endpackage

>>> sv/spf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subpixel peak fit request channel
// Carries a 3x3 gray window and a coarse point in fixed point.
// ----------------------------------------------------------------------------
interface spf_req_if #(
   parameter int COORD_W = spf_pkg::COORD_BITS_DEF + spf_pkg::IN_FRAC_BITS
);
   logic                       valid;
   logic                       ready;
   logic [spf_pkg::PIX_W-1:0]  pix_up_left;
   logic [spf_pkg::PIX_W-1:0]  pix_up;
   logic [spf_pkg::PIX_W-1:0]  pix_up_right;
   logic [spf_pkg::PIX_W-1:0]  pix_left;
   logic [spf_pkg::PIX_W-1:0]  pix_center;
   logic [spf_pkg::PIX_W-1:0]  pix_right;
   logic [spf_pkg::PIX_W-1:0]  pix_down_left;
   logic [spf_pkg::PIX_W-1:0]  pix_down;
   logic [spf_pkg::PIX_W-1:0]  pix_down_right;
   logic [COORD_W-1:0]         coarse_x;
   logic [COORD_W-1:0]         coarse_y;

   modport source (
      output valid, pix_up_left, pix_up, pix_up_right, pix_left, pix_center,
             pix_right, pix_down_left, pix_down, pix_down_right, coarse_x, coarse_y,
      input  ready
   );

   modport sink (
      input  valid, pix_up_left, pix_up, pix_up_right, pix_left, pix_center,
             pix_right, pix_down_left, pix_down, pix_down_right, coarse_x, coarse_y,
      output ready
   );
endinterface

>>> sv/spf_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subpixel peak fit response channel
// Carries the fit status and the refined point in fixed point.
// ----------------------------------------------------------------------------
interface spf_rsp_if #(
   parameter int REFINED_W = spf_pkg::COORD_BITS_DEF + spf_pkg::OUT_FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   spf_pkg::status_type  status;
   logic [REFINED_W-1:0] refined_x;
   logic [REFINED_W-1:0] refined_y;

   modport source (
      output valid, status, refined_x, refined_y,
      input  ready
   );

   modport sink (
      input  valid, status, refined_x, refined_y,
      output ready
   );
endinterface

>>> sv/spf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division with one quotient bit resolved per register stage.
// ----------------------------------------------------------------------------
module spf_div #(
   parameter int N_W = 34,
   parameter int D_W = 24,
   parameter int Q_W = 10
) (
   input  logic           clock,
   input  logic [Q_W-1:0] stage_en,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic [Q_W-1:0] quotient
);

   // The dividend must be below divisor * 2**Q_W.
   logic [N_W-1:0] rem_ff [Q_W-1];
   logic [D_W-1:0] dvs_ff [Q_W-1];
   logic [Q_W-1:0] quo_ff [Q_W];

   genvar j;
   generate
      for (j = 0; j < Q_W; j++) begin : g_stage
         localparam int BIT = Q_W - 1 - j;
         logic [N_W-1:0] rem_src;
         logic [D_W-1:0] dvs_src;
         logic [Q_W-1:0] quo_src;
         logic [N_W-1:0] trial;
         logic           take;
         logic [Q_W-1:0] quo_in;

         if (j == 0) begin : g_first
            assign rem_src = dividend;
            assign dvs_src = divisor;
            assign quo_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[j-1];
            assign dvs_src = dvs_ff[j-1];
            assign quo_src = quo_ff[j-1];
         end

         always_comb begin
            trial  = N_W'(dvs_src) << BIT;
            take   = (rem_src >= trial);
            quo_in = quo_src | (Q_W'(take) << BIT);
         end

         always_ff @(posedge clock) begin
            if (stage_en[j]) begin
               quo_ff[j] <= quo_in;
            end
         end

         if (j < Q_W - 1) begin : g_carry
            logic [N_W-1:0] rem_in;

            assign rem_in = take ? rem_src - trial : rem_src;

            always_ff @(posedge clock) begin
               if (stage_en[j]) begin
                  rem_ff[j] <= rem_in;
                  dvs_ff[j] <= dvs_src;
               end
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[Q_W-1];

endmodule

>>> sv/subpixel_peak_fit_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic subpixel peak fit on a 3x3 window
// Refines a coarse point from the gradient and Hessian of a gray window.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  req_ch    in         valid / ready    9 pixels, coarse_x, coarse_y
//  rsp_ch    out        valid / ready    status, refined_x, refined_y
//  csr_*     in         write enable     register index, write data
//
//  One transfer is taken per cycle unless the pipeline is full and stalled;
//  it has four arithmetic stages, one divider stage per quotient bit and the
//  output register. Reset clears all valid bits and loads the image size
//  registers. A stalled response holds only the stages that are full, so
//  empty stages still fill and request transfers continue until all are full.
// ----------------------------------------------------------------------------
module subpixel_peak_fit_3x3_core #(
   parameter int COORD_BITS    = spf_pkg::COORD_BITS_DEF,
   parameter int OUT_FRAC_BITS = spf_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [spf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spf_pkg::CSR_W-1:0]       csr_write_data,
   spf_req_if.sink                         req_ch,
   spf_rsp_if.source                       rsp_ch
);

   localparam int IFB     = spf_pkg::IN_FRAC_BITS;
   localparam int COORD_W = COORD_BITS + IFB;
   localparam int C_W     = COORD_BITS + 1;
   localparam int OW      = COORD_BITS + OUT_FRAC_BITS;
   localparam int QB      = OUT_FRAC_BITS + 2;
   localparam int N_W     = spf_pkg::DEN_W + QB;
   localparam int VW      = OW + 2;
   localparam int CMP_W   = (C_W + 1 > spf_pkg::CSR_W) ? C_W + 1 : spf_pkg::CSR_W;
   localparam int ST_DIV  = 4;
   localparam int ST_OUT  = ST_DIV + QB;
   localparam int NS      = ST_OUT + 1;

   localparam int PIX_W = spf_pkg::PIX_W;
   localparam int DX_W  = spf_pkg::DX_W;
   localparam int DH_W  = spf_pkg::DH_W;
   localparam int PR_W  = spf_pkg::PR_W;
   localparam int DT_W  = spf_pkg::DT_W;
   localparam int NX_W  = spf_pkg::NX_W;
   localparam int DEN_W = spf_pkg::DEN_W;

   localparam logic [OW-1:0] MAXV = '1;

   typedef struct packed {
      spf_pkg::status_type status;
      logic [C_W-1:0]      cx;
      logic [C_W-1:0]      cy;
      logic [OW-1:0]       fail_x;
      logic [OW-1:0]       fail_y;
   } side_type;

   // Configuration registers.
   logic [spf_pkg::CSR_W-1:0] width_ff;
   logic [spf_pkg::CSR_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= spf_pkg::IMAGE_WIDTH_RST;
         height_ff <= spf_pkg::IMAGE_HEIGHT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            spf_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data;
            spf_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage valid bits and stall control.
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] stage_en;

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_ctl
         assign stage_en[k] = rsp_ch.ready | ~(&vld_ff[NS-1:k]);
         if (k == 0) begin : g_head
            assign vld_in[k] = req_ch.valid;
         end else begin : g_body
            assign vld_in[k] = vld_ff[k-1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_ch.ready = stage_en[0];

   // Stage 1: rounding, bounds test and central differences.
   logic [COORD_W:0]          sum_x;
   logic [COORD_W:0]          sum_y;
   logic [C_W-1:0]            cx;
   logic [C_W-1:0]            cy;
   logic                      oob;
   logic signed [DX_W-1:0]    dx2_in;
   logic signed [DX_W-1:0]    dy2_in;
   logic signed [DH_W-1:0]    dxx_in;
   logic signed [DH_W-1:0]    dyy_in;
   logic signed [DH_W-1:0]    dxy4_in;
   side_type                  s1_side_in;

   function automatic logic signed [DH_W-1:0] widen(input logic [PIX_W-1:0] p);
      widen = $signed({{(DH_W - PIX_W){1'b0}}, p});
   endfunction

   always_comb begin
      sum_x = (COORD_W + 1)'(req_ch.coarse_x) + (COORD_W + 1)'(1 << (IFB - 1));
      sum_y = (COORD_W + 1)'(req_ch.coarse_y) + (COORD_W + 1)'(1 << (IFB - 1));
      cx    = sum_x[COORD_W:IFB];
      cy    = sum_y[COORD_W:IFB];
      oob   = (cx == '0) || (cy == '0) ||
              (CMP_W'(cx) + CMP_W'(1) >= CMP_W'(width_ff)) ||
              (CMP_W'(cy) + CMP_W'(1) >= CMP_W'(height_ff));

      dx2_in  = DX_W'(widen(req_ch.pix_right) - widen(req_ch.pix_left));
      dy2_in  = DX_W'(widen(req_ch.pix_down) - widen(req_ch.pix_up));
      dxx_in  = widen(req_ch.pix_right) + widen(req_ch.pix_left) -
                (widen(req_ch.pix_center) <<< 1);
      dyy_in  = widen(req_ch.pix_down) + widen(req_ch.pix_up) -
                (widen(req_ch.pix_center) <<< 1);
      dxy4_in = widen(req_ch.pix_down_right) - widen(req_ch.pix_up_right) -
                widen(req_ch.pix_down_left) + widen(req_ch.pix_up_left);

      s1_side_in.status = oob ? spf_pkg::STATUS_OOB : spf_pkg::STATUS_OK;
      s1_side_in.cx     = cx;
      s1_side_in.cy     = cy;
      s1_side_in.fail_x = OW'(req_ch.coarse_x) << (OUT_FRAC_BITS - IFB);
      s1_side_in.fail_y = OW'(req_ch.coarse_y) << (OUT_FRAC_BITS - IFB);
   end

   logic signed [DX_W-1:0] s1_dx2_ff;
   logic signed [DX_W-1:0] s1_dy2_ff;
   logic signed [DH_W-1:0] s1_dxx_ff;
   logic signed [DH_W-1:0] s1_dyy_ff;
   logic signed [DH_W-1:0] s1_dxy4_ff;
   side_type               s1_side_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_dx2_ff  <= dx2_in;
         s1_dy2_ff  <= dy2_in;
         s1_dxx_ff  <= dxx_in;
         s1_dyy_ff  <= dyy_in;
         s1_dxy4_ff <= dxy4_in;
         s1_side_ff <= s1_side_in;
      end
   end

   // Stage 2: products of the Hessian and gradient terms.
   logic signed [PR_W-1:0] s2_hh_ff;
   logic signed [PR_W-1:0] s2_xy_ff;
   logic signed [PR_W-1:0] s2_nxa_ff;
   logic signed [PR_W-1:0] s2_nxb_ff;
   logic signed [PR_W-1:0] s2_nya_ff;
   logic signed [PR_W-1:0] s2_nyb_ff;
   side_type               s2_side_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_hh_ff   <= PR_W'(s1_dxx_ff) * PR_W'(s1_dyy_ff);
         s2_xy_ff   <= PR_W'(s1_dxy4_ff) * PR_W'(s1_dxy4_ff);
         s2_nxa_ff  <= PR_W'(s1_dyy_ff) * PR_W'(s1_dx2_ff);
         s2_nxb_ff  <= PR_W'(s1_dxy4_ff) * PR_W'(s1_dy2_ff);
         s2_nya_ff  <= PR_W'(s1_dxx_ff) * PR_W'(s1_dy2_ff);
         s2_nyb_ff  <= PR_W'(s1_dxy4_ff) * PR_W'(s1_dx2_ff);
         s2_side_ff <= s1_side_ff;
      end
   end

   // Stage 3: scaled determinant and numerators.
   logic signed [DT_W-1:0] s3_dt_ff;
   logic signed [NX_W-1:0] s3_nx_ff;
   logic signed [NX_W-1:0] s3_ny_ff;
   side_type               s3_side_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_dt_ff   <= (DT_W'(s2_hh_ff) <<< 4) - DT_W'(s2_xy_ff);
         s3_nx_ff   <= (NX_W'(s2_nxa_ff) <<< 2) - NX_W'(s2_nxb_ff);
         s3_ny_ff   <= (NX_W'(s2_nya_ff) <<< 2) - NX_W'(s2_nyb_ff);
         s3_side_ff <= s2_side_ff;
      end
   end

   // Stage 4: singular and offset tests, divider operands.
   // The dividend is offset so that the floored quotient stays nonnegative.
   logic [DEN_W-1:0]          den;
   logic [NX_W-1:0]           abs_nx;
   logic [NX_W-1:0]           abs_ny;
   logic signed [NX_W-1:0]    sx;
   logic signed [NX_W-1:0]    sy;
   logic signed [DEN_W+1:0]   bias_x;
   logic signed [DEN_W+1:0]   bias_y;
   logic                      singular;
   logic                      too_far;
   logic [N_W-1:0]            num_x_in;
   logic [N_W-1:0]            num_y_in;
   logic [DEN_W-1:0]          dvs_in;
   side_type                  s4_side_in;

   always_comb begin
      den      = s3_dt_ff[DT_W-1] ? DEN_W'(-s3_dt_ff) : DEN_W'(s3_dt_ff);
      abs_nx   = s3_nx_ff[NX_W-1] ? NX_W'(-s3_nx_ff) : NX_W'(s3_nx_ff);
      abs_ny   = s3_ny_ff[NX_W-1] ? NX_W'(-s3_ny_ff) : NX_W'(s3_ny_ff);
      singular = (s3_dt_ff == '0);
      too_far  = (DEN_W'({abs_nx, 1'b0}) > den) || (DEN_W'({abs_ny, 1'b0}) > den);
      sx       = s3_dt_ff[DT_W-1] ? s3_nx_ff : -s3_nx_ff;
      sy       = s3_dt_ff[DT_W-1] ? s3_ny_ff : -s3_ny_ff;
      bias_x   = (DEN_W + 2)'(sx) + $signed({2'b00, den});
      bias_y   = (DEN_W + 2)'(sy) + $signed({2'b00, den});
      num_x_in = (N_W'(bias_x[DEN_W-1:0]) << QB) + N_W'(den);
      num_y_in = (N_W'(bias_y[DEN_W-1:0]) << QB) + N_W'(den);
      dvs_in   = {den[DEN_W-2:0], 1'b0};

      s4_side_in = s3_side_ff;
      if (s3_side_ff.status == spf_pkg::STATUS_OK) begin
         if (singular) begin
            s4_side_in.status = spf_pkg::STATUS_SINGULAR;
         end else if (too_far) begin
            s4_side_in.status = spf_pkg::STATUS_OFFSET;
         end
      end
   end

   logic [N_W-1:0]   s4_num_x_ff;
   logic [N_W-1:0]   s4_num_y_ff;
   logic [DEN_W-1:0] s4_dvs_ff;
   side_type         s4_side_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_num_x_ff <= num_x_in;
         s4_num_y_ff <= num_y_in;
         s4_dvs_ff   <= dvs_in;
         s4_side_ff  <= s4_side_in;
      end
   end

   // Divider stages.
   logic [QB-1:0] quo_x;
   logic [QB-1:0] quo_y;

   spf_div #(.N_W(N_W), .D_W(DEN_W), .Q_W(QB)) u_div_x (
      .clock    (clock),
      .stage_en (stage_en[ST_DIV +: QB]),
      .dividend (s4_num_x_ff),
      .divisor  (s4_dvs_ff),
      .quotient (quo_x)
   );

   spf_div #(.N_W(N_W), .D_W(DEN_W), .Q_W(QB)) u_div_y (
      .clock    (clock),
      .stage_en (stage_en[ST_DIV +: QB]),
      .dividend (s4_num_y_ff),
      .divisor  (s4_dvs_ff),
      .quotient (quo_y)
   );

   side_type side_ff [QB];

   generate
      for (k = 0; k < QB; k++) begin : g_side
         if (k == 0) begin : g_head
            always_ff @(posedge clock) begin
               if (stage_en[ST_DIV]) begin
                  side_ff[k] <= s4_side_ff;
               end
            end
         end else begin : g_body
            always_ff @(posedge clock) begin
               if (stage_en[ST_DIV + k]) begin
                  side_ff[k] <= side_ff[k-1];
               end
            end
         end
      end
   endgenerate

   // Output stage: remove the quotient offset, add the pixel and saturate.
   function automatic logic [OW-1:0] place(input logic [C_W-1:0] c,
                                           input logic [QB-1:0] q);
      logic [VW-1:0] vsum;
      logic [VW-1:0] vdiff;
      vsum  = (VW'(c) << OUT_FRAC_BITS) + VW'(q);
      vdiff = vsum - (VW'(1) << (QB - 1));
      if (vsum < (VW'(1) << (QB - 1))) begin
         place = '0;
      end else if (vdiff > VW'(MAXV)) begin
         place = MAXV;
      end else begin
         place = vdiff[OW-1:0];
      end
   endfunction

   side_type            last_side;
   spf_pkg::status_type out_status_ff;
   logic [OW-1:0]       out_x_ff;
   logic [OW-1:0]       out_y_ff;
   logic [OW-1:0]       out_x_in;
   logic [OW-1:0]       out_y_in;

   always_comb begin
      last_side = side_ff[QB-1];
      if (last_side.status == spf_pkg::STATUS_OK) begin
         out_x_in = place(last_side.cx, quo_x);
         out_y_in = place(last_side.cy, quo_y);
      end else begin
         out_x_in = last_side.fail_x;
         out_y_in = last_side.fail_y;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         out_status_ff <= last_side.status;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
      end
   end

   assign rsp_ch.valid     = vld_ff[ST_OUT];
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.refined_x = out_x_ff;
   assign rsp_ch.refined_y = out_y_ff;

endmodule
